[src/mrbt_pkg.sv]
`timescale 1ns / 1ps

package mrbt_pkg;

   localparam int ENTRIES   = 128;
   localparam int ADDR_BITS = 32;
   localparam int TAG_BITS  = 8;
   localparam int ACT_BITS  = 3;
   localparam int STAT_BITS = 2;
   localparam int PROBES    = 4;

   localparam logic [ACT_BITS-1:0] ACT_REGISTER   = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_UNREGISTER = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_QUERY      = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_SAME       = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_COPY       = 3'd4;

   localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_VIOLATION = 2'd3;

   // probe slots: start a, start b, last byte of a, last byte of b
   localparam int PRB_A      = 0;
   localparam int PRB_B      = 1;
   localparam int PRB_LAST_A = 2;
   localparam int PRB_LAST_B = 3;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_FINISH
   } state_type;

   typedef struct packed {
      logic [ACT_BITS-1:0]  action;
      logic [ADDR_BITS-1:0] address_a;
      logic [ADDR_BITS-1:0] address_b;
      logic [ADDR_BITS-1:0] length;
      logic [TAG_BITS-1:0]  region_tag;
   } req_type;

   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic [ADDR_BITS-1:0] bound_low;
      logic [ADDR_BITS:0]   bound_high;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic clear_wr;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

[src/mrbt_ctrl.sv]
`timescale 1ns / 1ps

module mrbt_ctrl #(
   parameter  int ENTRIES = mrbt_pkg::ENTRIES,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output mrbt_pkg::dp_cmd_type     cmd,
   output logic [IDX_W-1:0]         idx,
   input  mrbt_pkg::dp_stat_type    stat
);

   mrbt_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                last_idx;

   assign last_idx = (cnt_ff == IDX_W'(ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrbt_pkg::FSM_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         mrbt_pkg::FSM_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_idx) begin
               state_in = mrbt_pkg::FSM_IDLE;
               cnt_in   = '0;
            end
         end
         mrbt_pkg::FSM_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = mrbt_pkg::FSM_SCAN;
            end
         end
         mrbt_pkg::FSM_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_idx) begin
               state_in = mrbt_pkg::FSM_DRAIN;
               cnt_in   = '0;
            end
         end
         mrbt_pkg::FSM_DRAIN: begin
            state_in = mrbt_pkg::FSM_FINISH;
         end
         mrbt_pkg::FSM_FINISH: begin
            if (stat.out_free) begin
               state_in = mrbt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = mrbt_pkg::FSM_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      idx       = cnt_ff;
      unique case (state_ff)
         mrbt_pkg::FSM_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         mrbt_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mrbt_pkg::FSM_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         mrbt_pkg::FSM_DRAIN: begin
         end
         mrbt_pkg::FSM_FINISH: begin
            cmd.commit = stat.out_free;
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTH
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("result committed while output register busy");

   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cmd.scan_rd && idx == '0))
      else $error("scan did not start at entry zero after request");

   a_scan_to_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd && last_idx) |=> (state_ff == mrbt_pkg::FSM_DRAIN))
      else $error("scan did not end after last entry");
`endif

endmodule

[src/mrbt_dp.sv]
`timescale 1ns / 1ps

module mrbt_dp #(
   parameter  int ENTRIES = mrbt_pkg::ENTRIES,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mrbt_pkg::dp_cmd_type  cmd,
   input  logic [IDX_W-1:0]      idx,
   output mrbt_pkg::dp_stat_type stat,
   input  mrbt_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mrbt_pkg::rsp_type     rsp_data
);

   localparam int AW = mrbt_pkg::ADDR_BITS;
   localparam int TW = mrbt_pkg::TAG_BITS;
   localparam int NP = mrbt_pkg::PROBES;

   logic [AW-1:0] base_mem [ENTRIES];
   logic [AW-1:0] size_mem [ENTRIES];
   logic [TW-1:0] tag_mem  [ENTRIES];

   logic [mrbt_pkg::ACT_BITS-1:0] act_ff;
   logic [AW-1:0]                 len_ff;
   logic [TW-1:0]                 tag_ff;
   logic [AW-1:0]                 probe_ff [NP];
   logic [AW-1:0]                 probe_in [NP];
   logic                          ovf_a_ff, ovf_b_ff, ovf_a_in, ovf_b_in;
   logic [AW:0]                   sum_a, sum_b;

   logic [AW-1:0]    base_q, size_q;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [AW:0]      ent_hi;
   logic [NP-1:0]    hit;
   logic             free_hit;

   logic [NP-1:0]    found_ff;
   logic [AW-1:0]    fbase_ff [NP];
   logic [AW:0]      fhigh_ff [NP];
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff, hit_idx_ff;

   logic             reg_wr, unreg_wr, wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [AW-1:0]    wr_base, wr_size;
   logic [TW-1:0]    wr_tag;

   logic                  same_ab, same_a_rng, same_b_rng;
   logic                  rsp_valid_ff;
   mrbt_pkg::rsp_type     rsp_ff, rsp_in;

   // last byte of each copy range
   assign sum_a = {1'b0, req_data.address_a} + {1'b0, req_data.length} - (AW+1)'(1);
   assign sum_b = {1'b0, req_data.address_b} + {1'b0, req_data.length} - (AW+1)'(1);

   always_comb begin
      probe_in[mrbt_pkg::PRB_A] = req_data.address_a;
      probe_in[mrbt_pkg::PRB_B] = req_data.address_b;
      if (req_data.length == '0) begin
         probe_in[mrbt_pkg::PRB_LAST_A] = req_data.address_a;
         probe_in[mrbt_pkg::PRB_LAST_B] = req_data.address_b;
         ovf_a_in = 1'b0;
         ovf_b_in = 1'b0;
      end else begin
         probe_in[mrbt_pkg::PRB_LAST_A] = sum_a[AW-1:0];
         probe_in[mrbt_pkg::PRB_LAST_B] = sum_b[AW-1:0];
         ovf_a_in = sum_a[AW];
         ovf_b_in = sum_b[AW];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_data.action;
         len_ff   <= req_data.length;
         tag_ff   <= req_data.region_tag;
         ovf_a_ff <= ovf_a_in;
         ovf_b_ff <= ovf_b_in;
         for (int k = 0; k < NP; k++) begin
            probe_ff[k] <= probe_in[k];
         end
      end
   end

   // table memory, single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_mem[wr_idx] <= wr_base;
         size_mem[wr_idx] <= wr_size;
         tag_mem[wr_idx]  <= wr_tag;
      end
      if (cmd.scan_rd) begin
         base_q <= base_mem[idx];
         size_q <= size_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
      end
      rd_idx_ff <= idx;
   end

   assign ent_hi   = {1'b0, base_q} + {1'b0, size_q};
   assign free_hit = rd_vld_ff && (base_q == '0);

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         hit[k] = rd_vld_ff && (base_q <= probe_ff[k]) && (ent_hi > {1'b0, probe_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         found_ff      <= '0;
         free_found_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NP; k++) begin
            if (hit[k] && !found_ff[k]) begin
               found_ff[k] <= 1'b1;
            end
         end
         if (free_hit && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NP; k++) begin
         if (hit[k] && !found_ff[k]) begin
            fbase_ff[k] <= base_q;
            fhigh_ff[k] <= ent_hi;
         end
      end
      if (hit[mrbt_pkg::PRB_A] && !found_ff[mrbt_pkg::PRB_A]) begin
         hit_idx_ff <= rd_idx_ff;
      end
      if (free_hit && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   assign reg_wr   = (act_ff == mrbt_pkg::ACT_REGISTER) && (probe_ff[mrbt_pkg::PRB_A] != '0)
                     && free_found_ff;
   assign unreg_wr = (act_ff == mrbt_pkg::ACT_UNREGISTER) && found_ff[mrbt_pkg::PRB_A];
   assign wr_en    = cmd.clear_wr || (cmd.commit && (reg_wr || unreg_wr));

   always_comb begin
      wr_idx  = hit_idx_ff;
      wr_base = '0;
      wr_size = '0;
      wr_tag  = '0;
      if (cmd.clear_wr) begin
         wr_idx = idx;
      end else if (reg_wr) begin
         wr_idx  = free_idx_ff;
         wr_base = probe_ff[mrbt_pkg::PRB_A];
         wr_size = len_ff;
         wr_tag  = tag_ff;
      end
   end

   assign same_ab = found_ff[mrbt_pkg::PRB_A] && found_ff[mrbt_pkg::PRB_B]
                    && (fbase_ff[mrbt_pkg::PRB_A] == fbase_ff[mrbt_pkg::PRB_B])
                    && (fhigh_ff[mrbt_pkg::PRB_A] == fhigh_ff[mrbt_pkg::PRB_B]);
   assign same_a_rng = found_ff[mrbt_pkg::PRB_A] && found_ff[mrbt_pkg::PRB_LAST_A]
                       && (fbase_ff[mrbt_pkg::PRB_A] == fbase_ff[mrbt_pkg::PRB_LAST_A])
                       && (fhigh_ff[mrbt_pkg::PRB_A] == fhigh_ff[mrbt_pkg::PRB_LAST_A]);
   assign same_b_rng = found_ff[mrbt_pkg::PRB_B] && found_ff[mrbt_pkg::PRB_LAST_B]
                       && (fbase_ff[mrbt_pkg::PRB_B] == fbase_ff[mrbt_pkg::PRB_LAST_B])
                       && (fhigh_ff[mrbt_pkg::PRB_B] == fhigh_ff[mrbt_pkg::PRB_LAST_B]);

   always_comb begin
      rsp_in = '0;
      rsp_in.status = mrbt_pkg::ST_OK;
      unique case (act_ff)
         mrbt_pkg::ACT_REGISTER: begin
            if (probe_ff[mrbt_pkg::PRB_A] != '0 && !free_found_ff) begin
               rsp_in.status = mrbt_pkg::ST_FULL;
            end
         end
         mrbt_pkg::ACT_UNREGISTER: begin
            if (!found_ff[mrbt_pkg::PRB_A]) begin
               rsp_in.status = mrbt_pkg::ST_NOT_FOUND;
            end
         end
         mrbt_pkg::ACT_QUERY: begin
            if (found_ff[mrbt_pkg::PRB_A]) begin
               rsp_in.bound_low  = fbase_ff[mrbt_pkg::PRB_A];
               rsp_in.bound_high = fhigh_ff[mrbt_pkg::PRB_A];
            end else begin
               rsp_in.status = mrbt_pkg::ST_NOT_FOUND;
            end
         end
         mrbt_pkg::ACT_SAME: begin
            if (!found_ff[mrbt_pkg::PRB_A] || !found_ff[mrbt_pkg::PRB_B]) begin
               rsp_in.status = mrbt_pkg::ST_NOT_FOUND;
            end else if (!same_ab) begin
               rsp_in.status = mrbt_pkg::ST_VIOLATION;
            end
         end
         mrbt_pkg::ACT_COPY: begin
            if (ovf_a_ff || ovf_b_ff || !same_a_rng || !same_b_rng) begin
               rsp_in.status = mrbt_pkg::ST_VIOLATION;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

`ifndef SYNTH
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !cmd.scan_rd)
      else $error("table write during scan read");
`endif

endmodule

[src/memory_region_bounds_table_core.sv]
// Requests are accepted one at a time: a new request is stalled until the previous
// result is committed to the output register. Every request scans the whole table,
// one entry per cycle through the single registered read port.
// Reset: synchronous, active high; afterwards a clearing pass zeroes every table entry
// while requests are stalled.
`timescale 1ns / 1ps

module memory_region_bounds_table_core #(
   parameter  int ENTRIES = mrbt_pkg::ENTRIES,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrbt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrbt_pkg::rsp_type rsp_data
);

   mrbt_pkg::dp_cmd_type  cmd;
   mrbt_pkg::dp_stat_type stat;
   logic [IDX_W-1:0]      idx;

   mrbt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .idx       (idx),
      .stat      (stat)
   );

   mrbt_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idx       (idx),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
